### hdl/domain_wildcard_allowlist_match_defines.svh
// Assertion macros used by the top module to check its own behaviour.
`ifndef DOMAIN_WILDCARD_ALLOWLIST_MATCH_DEFINES_SVH
`define DOMAIN_WILDCARD_ALLOWLIST_MATCH_DEFINES_SVH
`ifndef ASSERT_OFF
`define DWAM_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define DWAM_ASSERT_NXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define DWAM_ASSERT_IMP(label, clk, rst, ante, cons)
`define DWAM_ASSERT_NXT(label, clk, ante, cons)
`endif
`endif

### hdl/dwam_pkg.sv
`default_nettype none
package dwam_pkg;

  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ENTRY = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [2:0] ST_ANSWERED = 3'd0;
  localparam logic [2:0] ST_STORED   = 3'd1;
  localparam logic [2:0] ST_SKIPPED  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_TOO_LONG = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEN_RD,
    S_LEN_CHK,
    S_BYTE_RD,
    S_BYTE_CMP
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic ready;
    logic len_chk;
    logic cmp;
    logic next_entry;
    logic finish_hit;
    logic finish_miss;
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_busy;
    logic start_lookup;
    logic more;
    logic alive0;
    logic alive_n;
    logic hit;
  } dp_stat_t;

endpackage
`default_nettype wire

### hdl/dwam_in_if.sv
`default_nettype none
interface dwam_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, command, data_byte, last, input ready);
  modport sink (input valid, command, data_byte, last, output ready);
endinterface
`default_nettype wire

### hdl/dwam_out_if.sv
`default_nettype none
interface dwam_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       matched;
  logic       loaded;
  logic [8:0] entry_count;

  modport source (output valid, status, matched, loaded, entry_count, input ready);
  modport sink (input valid, status, matched, loaded, entry_count, output ready);
endinterface
`default_nettype wire

### hdl/domain_wildcard_allowlist_match.sv
// Domain allow-list with exact and wildcard-suffix matching.
// The item channel carries one byte beat at a time: command 0 clears the table,
// command 1 adds a byte to the entry being loaded, command 2 adds a byte to the
// query; last marks the final byte. Every final entry or query byte gives one
// beat on the result channel with status, matched, loaded and entry_count.
// Entry and non-final query bytes are taken at one per cycle unless stalled, and
// the result of a final entry byte appears in the cycle after it is accepted.
// A final query byte starts a walk of the table unless the query is too long.
// During the walk the item channel is held off. For each stored entry the walk
// reads and checks its length, and in entries whose length allows a match it
// reads and compares the bytes one by one. The walk stops at the first entry
// that matches. A walk that finds no match ends when it sees that the table is
// exhausted. The answer goes through the result register. The speed of the
// walk is set by the registered read of the entry and query memories.
// A result waits in an output register. While it is not taken, the item
// channel is not ready, so a stalled receiver stalls the sender.
// Reset empties the table and discards partial entries and queries; no
// clearing pass is needed because only written bytes are ever read.
`default_nettype none
`include "domain_wildcard_allowlist_match_defines.svh"
module domain_wildcard_allowlist_match
  import dwam_pkg::*;
#(
  parameter int MAX_ENTRIES = 256,
  parameter int MAX_LEN = 256
) (
  input  wire logic  clk,
  input  wire logic  rst,
  dwam_in_if.sink    item,
  dwam_out_if.source result
);
  // Command and status between the sequencer and the datapath.
  ctl_cmd_t cmd;
  dp_stat_t stat;

  // The sequencer decides when beats are taken and walks the table.
  dwam_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // The datapath holds the entry, length and query memories and the counters.
  dwam_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_LEN     (MAX_LEN)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .cmd    (cmd),
    .stat   (stat)
  );

  // The input is only ready when the result register can take a new beat.
  `DWAM_ASSERT_IMP(a_ready_room, clk, rst, item.ready, !result.valid || result.ready)
  // Only a query answer can report a match.
  `DWAM_ASSERT_IMP(a_match_query, clk, rst, result.valid && result.matched,
                   result.status == ST_ANSWERED)
  // Reset leaves no result pending.
  `DWAM_ASSERT_NXT(a_reset_empty, clk, rst, !result.valid)
endmodule
`default_nettype wire

### hdl/dwam_ram.sv
`default_nettype none
module dwam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### hdl/dwam_ctrl.sv
`default_nettype none
module dwam_ctrl
  import dwam_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire dp_stat_t stat,
  output ctl_cmd_t      cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.ready = !stat.out_busy;
        if (stat.start_lookup) begin
          state_next = S_LEN_RD;
        end
      end
      S_LEN_RD: begin
        if (!stat.more) begin
          cmd.finish_miss = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_LEN_CHK;
        end
      end
      S_LEN_CHK: begin
        cmd.len_chk = 1'b1;
        if (stat.alive0) begin
          state_next = S_BYTE_RD;
        end else begin
          cmd.next_entry = 1'b1;
          state_next = S_LEN_RD;
        end
      end
      S_BYTE_RD: begin
        state_next = S_BYTE_CMP;
      end
      S_BYTE_CMP: begin
        cmd.cmp = 1'b1;
        if (stat.hit) begin
          cmd.finish_hit = 1'b1;
          state_next = S_IDLE;
        end else if (!stat.alive_n) begin
          cmd.next_entry = 1'b1;
          state_next = S_LEN_RD;
        end else begin
          state_next = S_BYTE_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

### hdl/dwam_dp.sv
`default_nettype none
module dwam_dp
  import dwam_pkg::*;
#(
  parameter int MAX_ENTRIES = 256,
  parameter int MAX_LEN = 256
) (
  input  wire logic     clk,
  input  wire logic     rst,
  dwam_in_if.sink       item,
  dwam_out_if.source    result,
  input  wire ctl_cmd_t cmd,
  output dp_stat_t      stat
);
  localparam int EAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int BAW = $clog2(MAX_LEN);
  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int PW  = BAW + 1;
  localparam int ENT_DEPTH = MAX_ENTRIES * (2 ** BAW);
  localparam logic [PW-1:0] LEN_LIMIT = PW'(MAX_LEN - 1);
  localparam logic [PW-1:0] LEN_SAT   = PW'(MAX_LEN);
  localparam logic [CW-1:0] ENT_LIMIT = CW'(MAX_ENTRIES);

  logic [CW-1:0]  sc;
  logic [PW-1:0]  lp;
  logic [7:0]     first_byte;
  logic [PW-1:0]  ql;
  logic [BAW-1:0] qlen;
  logic [CW-1:0]  idx;
  logic [BAW-1:0] elen;
  logic [BAW-1:0] j;
  logic           ex_ok;
  logic           wc_ok;

  logic           take, is_entry, is_query;
  logic           ent_keep, ent_we, len_we, q_we;
  logic [PW-1:0]  lp_inc, ql_inc;
  logic [7:0]     first_eff;
  logic [2:0]     ent_status;
  logic [CW-1:0]  sc_new;
  logic [CW+8:0]  sc_wide, sc_new_wide;
  logic           q_long;

  logic [BAW-1:0] len_rd;
  logic [7:0]     ent_rd, q0_rd, q1_rd;
  logic           ex0, wc0, ex_n, wc_n, wc_byte;

  assign item.ready = cmd.ready;
  assign take      = item.valid && cmd.ready;
  assign is_entry  = item.command == CMD_ENTRY;
  assign is_query  = item.command == CMD_QUERY;

  // Entry loading. A newline as the final byte is dropped.
  assign ent_keep  = !(item.last && item.data_byte == CH_NEWLINE);
  assign lp_inc    = (ent_keep && lp < LEN_SAT) ? lp + PW'(1) : lp;
  assign ent_we    = take && is_entry && ent_keep && lp < LEN_LIMIT && sc < ENT_LIMIT;
  assign first_eff = (lp == '0) ? item.data_byte : first_byte;

  always_comb begin
    len_we = 1'b0;
    sc_new = sc;
    if (sc >= ENT_LIMIT) begin
      ent_status = ST_FULL;
    end else if (lp_inc == '0 || first_eff == CH_HASH) begin
      ent_status = ST_SKIPPED;
    end else if (lp_inc > LEN_LIMIT) begin
      ent_status = ST_TOO_LONG;
    end else begin
      ent_status = ST_STORED;
      len_we = take && is_entry && item.last;
      sc_new = sc + CW'(1);
    end
  end

  assign sc_wide     = (CW + 9)'(sc);
  assign sc_new_wide = (CW + 9)'(sc_new);

  // Query receive.
  assign q_we   = take && is_query && ql < LEN_LIMIT;
  assign ql_inc = (ql < LEN_SAT) ? ql + PW'(1) : ql;
  assign q_long = ql_inc > LEN_LIMIT;

  dwam_ram #(.WIDTH(8), .DEPTH(ENT_DEPTH)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr ({sc[EAW-1:0], lp[BAW-1:0]}),
    .wdata (item.data_byte),
    .raddr ({idx[EAW-1:0], j}),
    .rdata (ent_rd)
  );

  dwam_ram #(.WIDTH(BAW), .DEPTH(MAX_ENTRIES)) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (sc[EAW-1:0]),
    .wdata (lp_inc[BAW-1:0]),
    .raddr (idx[EAW-1:0]),
    .rdata (len_rd)
  );

  // Two copies of the query: one read from the front, one aligned to the end.
  dwam_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_qhead_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (ql[BAW-1:0]),
    .wdata (item.data_byte),
    .raddr (j),
    .rdata (q0_rd)
  );

  dwam_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_qtail_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (ql[BAW-1:0]),
    .wdata (item.data_byte),
    .raddr (qlen - elen + j),
    .rdata (q1_rd)
  );

  // Candidate checks on the stored length, then byte by byte.
  assign ex0 = len_rd == qlen;
  assign wc0 = (len_rd >= BAW'(2)) && ({1'b0, len_rd} <= {1'b0, qlen} + PW'(1));

  always_comb begin
    if (j == '0) begin
      wc_byte = ent_rd == CH_STAR;
    end else if (j == BAW'(1)) begin
      wc_byte = ent_rd == CH_DOT && ent_rd == q1_rd;
    end else begin
      wc_byte = ent_rd == q1_rd;
    end
  end

  assign ex_n = ex_ok && ent_rd == q0_rd;
  assign wc_n = wc_ok && wc_byte;

  assign stat.out_busy     = result.valid && !result.ready;
  assign stat.start_lookup = take && is_query && item.last && !q_long;
  assign stat.more         = idx < sc;
  assign stat.alive0       = ex0 || wc0;
  assign stat.alive_n      = ex_n || wc_n;
  assign stat.hit          = (ex_n || wc_n) && j == elen - BAW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      sc <= '0;
      lp <= '0;
      ql <= '0;
    end else if (take) begin
      case (item.command)
        CMD_CLEAR: begin
          sc <= '0;
          lp <= '0;
          ql <= '0;
        end
        CMD_ENTRY: begin
          if (item.last) begin
            lp <= '0;
            sc <= sc_new;
          end else begin
            lp <= lp_inc;
          end
        end
        CMD_QUERY: begin
          ql <= item.last ? '0 : ql_inc;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ent_we && lp == '0) begin
      first_byte <= item.data_byte;
    end
    if (stat.start_lookup) begin
      qlen <= ql_inc[BAW-1:0];
      idx  <= '0;
    end else if (cmd.next_entry) begin
      idx <= idx + CW'(1);
    end
    if (cmd.len_chk) begin
      elen  <= len_rd;
      ex_ok <= ex0;
      wc_ok <= wc0;
      j     <= '0;
    end else if (cmd.cmp) begin
      ex_ok <= ex_n;
      wc_ok <= wc_n;
      j     <= j + BAW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (take && is_entry && item.last) begin
      result.valid <= 1'b1;
    end else if (take && is_query && item.last && q_long) begin
      result.valid <= 1'b1;
    end else if (cmd.finish_hit || cmd.finish_miss) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && is_entry && item.last) begin
      result.status      <= ent_status;
      result.matched     <= 1'b0;
      result.loaded      <= sc_new != '0;
      result.entry_count <= sc_new_wide[8:0];
    end else if (take && is_query && item.last && q_long) begin
      result.status      <= ST_TOO_LONG;
      result.matched     <= 1'b0;
      result.loaded      <= sc != '0;
      result.entry_count <= sc_wide[8:0];
    end else if (cmd.finish_hit || cmd.finish_miss) begin
      result.status      <= ST_ANSWERED;
      result.matched     <= cmd.finish_hit;
      result.loaded      <= sc != '0;
      result.entry_count <= sc_wide[8:0];
    end
  end
endmodule
`default_nettype wire
